// ----- rtl/ultrasonic_ranger_register_slave_defines.svh -----
// ---------------------------------------------------------------------------
// Ultrasonic ranger assertion macros
// Shorthand for the concurrent checks in the ranger RTL. Each macro expects
// signals named clk and rst in the module where it is used.
// ---------------------------------------------------------------------------
`ifndef ULTRASONIC_RANGER_REGISTER_SLAVE_DEFINES_SVH
`define ULTRASONIC_RANGER_REGISTER_SLAVE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define USR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define USR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/usr_pkg.sv -----
// ---------------------------------------------------------------------------
// Ultrasonic ranger package
// Command codes, register addresses, control bits and reset values.
// ---------------------------------------------------------------------------
`default_nettype none

package usr_pkg;

  localparam int TIMER_BITS_DEFAULT = 32;
  localparam int CFG_INDEX_BITS     = 1;
  localparam int CFG_DATA_BITS      = 32;

  // Item commands.
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_EDGE  = 2'd2;
  localparam logic [1:0] CMD_POLL  = 2'd3;

  // Bus register map.
  localparam logic [7:0] ADDR_CTRL = 8'h00;
  localparam logic [7:0] ADDR_DIST = 8'h01;

  // Bit positions of the control/status byte.
  localparam int CTRL_READY_POS  = 7;
  localparam int CTRL_CONT_POS   = 6;
  localparam int CTRL_SINGLE_POS = 5;

  // Byte counts returned by a read.
  localparam logic [1:0] NBYTES_NONE   = 2'd0;
  localparam logic [1:0] NBYTES_STATUS = 2'd1;
  localparam logic [1:0] NBYTES_DIST   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_COUNTER_TOP = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DIST_SCALE  = 1'd1;

  localparam logic [31:0] COUNTER_TOP_RESET = 32'hFFFF_FFFF;
  localparam logic [15:0] DIST_SCALE_RESET  = 16'd11239;
  localparam logic [15:0] DIST_INVALID      = 16'hFFFF;

endpackage

`default_nettype wire

// ----- rtl/ultrasonic_ranger_register_slave.sv -----
// ---------------------------------------------------------------------------
// Ultrasonic ranger register slave
// Echo-time rangefinder with a control/status register and a distance
// register, driven by a stream of bus, echo-edge and poll words.
// ---------------------------------------------------------------------------
// Usage:
//   Input words (item_valid/item_ready) carry a command: a register write, a
//   register read, a timer capture taken at an echo edge, or a poll step
//   that may start a trigger pulse. Every input word yields exactly one
//   result word (result_valid/result_ready) in the same order.
//   A word is first taken into the input register; once the result register
//   is free or being emptied, the single-pass logic updates the ranger state
//   and loads the result register. One word is accepted in every cycle while
//   results are taken; the path holds one input register and one result
//   register, with the echo-duration multiply between them.
//   When the receiver stalls, the result register holds its word, the input
//   register holds at most one more, and item_ready then drops until the
//   result is taken, so nothing is lost or repeated.
//   The configuration port (cfg_we, cfg_index, cfg_data) sets the timer
//   reload value and the distance scale; it is meant to be written while no
//   words are in flight. Synchronous reset empties both registers, clears
//   the control flags and marks the distance invalid (all ones).
// ---------------------------------------------------------------------------
`default_nettype none

`include "ultrasonic_ranger_register_slave_defines.svh"

module ultrasonic_ranger_register_slave
  import usr_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // Configuration write port.
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  // Input words.
  input  wire logic                      item_valid,
  output logic                           item_ready,
  input  wire logic [1:0]                cmd,
  input  wire logic [7:0]                reg_addr,
  input  wire logic [7:0]                write_data,
  input  wire logic [31:0]               capture_value,
  // Result words.
  output logic                           result_valid,
  input  wire logic                      result_ready,
  output logic                           trigger_fire,
  output logic [1:0]                     read_bytes,
  output logic [15:0]                    read_data,
  output logic                           measure_done
);

  localparam int PROD_BITS = TIMER_BITS + 16;
  // Largest distance that fits the 16-bit register, at timer width.
  localparam logic [TIMER_BITS-1:0] DIST_MAX = TIMER_BITS'(DIST_INVALID);

  // Configuration registers.
  logic [31:0] counter_top;
  logic [15:0] distance_scale_q16;

  always_ff @(posedge clk) begin
    if (rst) begin
      counter_top        <= COUNTER_TOP_RESET;
      distance_scale_q16 <= DIST_SCALE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COUNTER_TOP: counter_top        <= cfg_data;
        CFG_DIST_SCALE:  distance_scale_q16 <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Input register. The word in it is processed once the result register
  // is free, or is being emptied in the same cycle.
  logic                  item_held;
  logic [1:0]            cmd_q;
  logic [7:0]            addr_q;
  logic [7:0]            data_q;
  logic [TIMER_BITS-1:0] cap_q;
  logic                  advance;

  assign advance    = item_held && (!result_valid || result_ready);
  assign item_ready = !item_held || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_held <= 1'b0;
    end else if (item_ready) begin
      item_held <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      cmd_q  <= cmd;
      addr_q <= reg_addr;
      data_q <= write_data;
      cap_q  <= capture_value[TIMER_BITS-1:0];
    end
  end

  // Ranger state.
  logic                  continuous_mode;
  logic                  single_pending;
  logic                  ready_flag;
  logic                  measurement_complete;
  logic                  capture_armed;
  logic                  echo_phase;
  logic [TIMER_BITS-1:0] rise_count;
  logic [15:0]           distance_value;

  logic                  continuous_mode_next;
  logic                  single_pending_next;
  logic                  ready_flag_next;
  logic                  measurement_complete_next;
  logic                  capture_armed_next;
  logic                  echo_phase_next;
  logic [TIMER_BITS-1:0] rise_count_next;
  logic [15:0]           distance_value_next;

  logic                  fire_next;
  logic [1:0]            nbytes_next;
  logic [15:0]           rdata_next;
  logic                  done_next;

  // Echo duration. A falling capture at or below the rising one means the
  // timer rolled over at counter_top in between.
  logic [TIMER_BITS-1:0] diff;
  logic [TIMER_BITS-1:0] wrapped;
  logic [TIMER_BITS-1:0] ticks;
  logic [PROD_BITS-1:0]  product;
  logic [TIMER_BITS-1:0] dist_raw;
  logic [15:0]           dist_sat;

  always_comb begin
    diff     = cap_q - rise_count;
    wrapped  = counter_top[TIMER_BITS-1:0] + diff + TIMER_BITS'(1);
    ticks    = (cap_q > rise_count) ? diff : wrapped;
    product  = PROD_BITS'(ticks) * PROD_BITS'(distance_scale_q16);
    dist_raw = product[PROD_BITS-1:16];
    dist_sat = (dist_raw > DIST_MAX) ? DIST_INVALID : dist_raw[15:0];
  end

  always_comb begin
    continuous_mode_next      = continuous_mode;
    single_pending_next       = single_pending;
    ready_flag_next           = ready_flag;
    measurement_complete_next = measurement_complete;
    capture_armed_next        = capture_armed;
    echo_phase_next           = echo_phase;
    rise_count_next           = rise_count;
    distance_value_next       = distance_value;
    fire_next                 = 1'b0;
    nbytes_next               = NBYTES_NONE;
    rdata_next                = 16'd0;
    done_next                 = 1'b0;

    case (cmd_q)
      CMD_WRITE: begin
        // The ready bit is read-only; other bits of the byte are dropped.
        if (addr_q == ADDR_CTRL) begin
          continuous_mode_next = data_q[CTRL_CONT_POS];
          single_pending_next  = data_q[CTRL_SINGLE_POS];
        end
      end
      CMD_READ: begin
        if (addr_q == ADDR_CTRL) begin
          nbytes_next                  = NBYTES_STATUS;
          rdata_next[CTRL_READY_POS]   = ready_flag;
          rdata_next[CTRL_CONT_POS]    = continuous_mode;
          rdata_next[CTRL_SINGLE_POS]  = single_pending;
        end else if (addr_q == ADDR_DIST) begin
          nbytes_next = NBYTES_DIST;
          rdata_next  = distance_value;
        end
      end
      CMD_EDGE: begin
        if (capture_armed) begin
          if (!echo_phase) begin
            rise_count_next = cap_q;
            echo_phase_next = 1'b1;
          end else if (!measurement_complete) begin
            distance_value_next       = dist_sat;
            ready_flag_next           = 1'b1;
            measurement_complete_next = 1'b1;
            echo_phase_next           = 1'b0;
            capture_armed_next        = 1'b0;
            done_next                 = 1'b1;
          end
        end
      end
      CMD_POLL: begin
        // A pending single shot takes precedence over continuous mode.
        if (single_pending || (continuous_mode && measurement_complete)) begin
          single_pending_next       = 1'b0;
          capture_armed_next        = 1'b1;
          measurement_complete_next = 1'b0;
          ready_flag_next           = 1'b0;
          echo_phase_next           = 1'b0;
          fire_next                 = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      continuous_mode      <= 1'b0;
      single_pending       <= 1'b0;
      ready_flag           <= 1'b0;
      measurement_complete <= 1'b0;
      capture_armed        <= 1'b0;
      echo_phase           <= 1'b0;
      rise_count           <= '0;
      distance_value       <= DIST_INVALID;
    end else if (advance) begin
      continuous_mode      <= continuous_mode_next;
      single_pending       <= single_pending_next;
      ready_flag           <= ready_flag_next;
      measurement_complete <= measurement_complete_next;
      capture_armed        <= capture_armed_next;
      echo_phase           <= echo_phase_next;
      rise_count           <= rise_count_next;
      distance_value       <= distance_value_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      trigger_fire <= fire_next;
      read_bytes   <= nbytes_next;
      read_data    <= rdata_next;
      measure_done <= done_next;
    end
  end

  `USR_ASSERT_NOW(a_armed_not_complete, 1'b1, !(capture_armed && measurement_complete), "capture armed while a measurement is complete")
  `USR_ASSERT_NEXT(a_advance_gives_result, advance, result_valid, "processed word produced no result")
  `USR_ASSERT_NOW(a_done_sets_ready, result_valid && measure_done, ready_flag && !capture_armed, "completed measurement left ready clear or capture armed")
  `USR_ASSERT_NOW(a_fire_rearms, result_valid && trigger_fire, capture_armed && !ready_flag && !echo_phase, "trigger fired without re-arming capture")
  `USR_ASSERT_NOW(a_read_bytes_range, result_valid, read_bytes != 2'd3, "read byte count out of range")

endmodule

`default_nettype wire
